// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/bset_pkg.sv =====
// ---------------------------------------------------------------------------
// Bounded set package
// Sizes, status codes and transaction types of the bounded set table.
// ---------------------------------------------------------------------------
package bset_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_ABSENT   = 3'd4;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic eq;
        logic last;
    } cmp_res_t;

endpackage

// ===== sv/bset_store.sv =====
// ---------------------------------------------------------------------------
// Bounded set entry store
// One write port and one registered read port over the packed entries.
// ---------------------------------------------------------------------------
module bset_store
    import bset_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bset_cmp.sv =====
// ---------------------------------------------------------------------------
// Bounded set compare unit
// Shared key match and end-of-set detection used by search and shift.
// ---------------------------------------------------------------------------
module bset_cmp
    import bset_pkg::*;
(
    input  logic [DATA_W-1:0] data,
    input  logic [DATA_W-1:0] key,
    input  logic [CNT_W-1:0]  pos,
    input  logic [CNT_W-1:0]  held,
    output cmp_res_t          res
);

    assign res.eq   = (data == key);
    assign res.last = (pos == held);

endmodule

// ===== sv/bounded_unique_set_table.sv =====
// ---------------------------------------------------------------------------
// Bounded unique set table
// Insert or remove one signed value per transaction; entries stay packed.
// Done strobes in the cycle after start on an empty set or on an insert
//   into a full set; otherwise the entries are searched one by one and, on
//   a remove, the later entries are shifted down. The single memory port
//   paces search and shift.
// Throughput: one transaction at a time; busy is high while a search or shift runs.
// Reset: rst_n clears the count and sequencer; entries hold stale data.
// ---------------------------------------------------------------------------
module bounded_unique_set_table
    import bset_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic              kind_reg, kind_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;

    mem_req_t          req;
    logic [DATA_W-1:0] rdata;
    cmp_res_t          cmp;
    logic [CNT_W-1:0]  pos;

    bset_store u_store
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign pos = {1'b0, idx_reg} + ((state_reg == S_SHIFT) ? CNT_W'(2) : CNT_W'(1));

    bset_cmp u_cmp
    (
        .data (rdata),
        .key  (key_reg),
        .pos  (pos),
        .held (held_reg),
        .res  (cmp)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        held_next  = held_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        req.we     = 1'b0;
        req.waddr  = idx_reg;
        req.wdata  = rdata;
        req.raddr  = idx_reg + IDX_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                req.raddr = '0;
                if (start)
                begin
                    kind_next = item.kind;
                    key_next  = item.value;
                    idx_next  = '0;
                    if (item.kind == KIND_INSERT && held_reg == CNT_W'(CAPACITY))
                    begin
                        done_next       = 1'b1;
                        res_next.status = ST_FULL;
                        res_next.count  = held_reg;
                    end
                    else if (held_reg == '0)
                    begin
                        done_next = 1'b1;
                        if (item.kind == KIND_INSERT)
                        begin
                            req.we          = 1'b1;
                            req.waddr       = '0;
                            req.wdata       = item.value;
                            held_next       = CNT_W'(1);
                            res_next.status = ST_INSERTED;
                            res_next.count  = CNT_W'(1);
                        end
                        else
                        begin
                            res_next.status = ST_ABSENT;
                            res_next.count  = '0;
                        end
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (cmp.eq)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        done_next       = 1'b1;
                        res_next.status = ST_PRESENT;
                        res_next.count  = held_reg;
                        state_next      = S_IDLE;
                    end
                    else if (cmp.last)
                    begin
                        done_next       = 1'b1;
                        held_next       = held_reg - CNT_W'(1);
                        res_next.status = ST_REMOVED;
                        res_next.count  = held_reg - CNT_W'(1);
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (cmp.last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (kind_reg == KIND_INSERT)
                    begin
                        req.we          = 1'b1;
                        req.waddr       = held_reg[IDX_W-1:0];
                        req.wdata       = key_reg;
                        held_next       = held_reg + CNT_W'(1);
                        res_next.status = ST_INSERTED;
                        res_next.count  = held_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_next.status = ST_ABSENT;
                        res_next.count  = held_reg;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SHIFT:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = rdata;
                req.raddr = idx_reg + IDX_W'(2);
                if (cmp.last)
                begin
                    done_next       = 1'b1;
                    held_next       = held_reg - CNT_W'(1);
                    res_next.status = ST_REMOVED;
                    res_next.count  = held_reg - CNT_W'(1);
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== sv/bset_checker.sv =====
// ---------------------------------------------------------------------------
// Bounded set port checker
// Port-level properties of the bounded set table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bset_checker
    import bset_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    `ASSERT_NXT(a_accept_progress, start && !busy, done || busy)
    `ASSERT_IMP(a_count_bound, done, result.count <= CNT_W'(CAPACITY))
    `ASSERT_IMP(a_status_code, done, result.status <= ST_ABSENT)
    `ASSERT_IMP(a_insert_nonempty, done && result.status == ST_INSERTED, result.count != '0)
    `ASSERT_IMP(a_full_count, done && result.status == ST_FULL, result.count == CNT_W'(CAPACITY))

endmodule

bind bounded_unique_set_table bset_checker u_bset_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
